[sv/vdq_pkg.sv]
package vdq_pkg;

  // widths fixed by the field layout
  localparam int unsigned PinW      = 16;
  localparam int unsigned PinSelW   = 4;
  localparam int unsigned DelayW    = 8;
  localparam int unsigned FilterW   = 8;
  localparam int unsigned DwellW    = 16;
  localparam int unsigned DelayCntW = 18;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 2;

  // channels that show up in a result, and the number of fields in the pin and delay maps
  localparam int unsigned ShownChannels = 4;
  localparam int unsigned MapSlots      = 4;

  localparam logic [DelayCntW-1:0] DelayUnit = DelayCntW'(1000);
  localparam logic [DwellW-1:0]    DwellMax  = {DwellW{1'b1}};

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPinMap   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDelays   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFilter   = 2'd2;

  // configuration register reset values
  localparam logic [PinW-1:0]          PinMapReset = 16'h3210;
  localparam logic [MapSlots*DelayW-1:0] DelaysReset = '0;
  localparam logic [FilterW-1:0]       FilterReset = 8'd3;

  localparam int unsigned ResultW = 2*ShownChannels + ShownChannels*DwellW;

  typedef struct packed {
    logic [PinSelW-1:0] pin_sel;
    logic [DelayW-1:0]  delay;
    logic [FilterW-1:0] filter;
  } chan_cfg_t;

  typedef struct packed {
    logic              presence;
    logic              valid;
    logic [DwellW-1:0] dwell;
  } chan_stat_t;

  // packed from the top bit down: dwell3 .. dwell0, valid, presence
  typedef struct packed {
    logic [DwellW-1:0]        dwell3;
    logic [DwellW-1:0]        dwell2;
    logic [DwellW-1:0]        dwell1;
    logic [DwellW-1:0]        dwell0;
    logic [ShownChannels-1:0] valid_bits;
    logic [ShownChannels-1:0] presence_bits;
  } result_t;

endpackage

[sv/vehicle_detector_qualifier.sv]
// channel      | dir | payload (low bit up)                               | accepted when
// -------------+-----+----------------------------------------------------+-----------------
// s_axis       | in  | tdata[15:0] pin_levels                             | tvalid && tready
// m_axis       | out | tdata: presence_bits, valid_bits, dwell_ch0..3     | tvalid && tready
// cfg          | in  | cfg_idx_i selects pin_map, channel_delays, filters | cfg_we_i
//
// one item per cycle while the result is not stalled: all channels update in parallel
// in the cycle an item is accepted and the result register is loaded at that same edge
// reset clears all channel state and loads the register defaults
// s_axis_tready_o stays high while the result register is empty or being
// drained, so a new item enters in the cycle a waiting result is taken
module vehicle_detector_qualifier #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pin_levels[15:0]
  input  logic [15:0]                       s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // presence_bits[3:0], valid_bits[7:4], dwell_ch0[23:8], dwell_ch1[39:24],
  // dwell_ch2[55:40], dwell_ch3[71:56]
  output logic [vdq_pkg::ResultW-1:0]       m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  input  logic                              cfg_we_i,
  input  logic [vdq_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [vdq_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import vdq_pkg::*;

  // configuration registers
  logic [PinW-1:0]             pin_map_q;
  logic [MapSlots*DelayW-1:0]  delays_q;
  logic [FilterW-1:0]          filter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_map_q <= PinMapReset;
      delays_q  <= DelaysReset;
      filter_q  <= FilterReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPinMap: pin_map_q <= cfg_wdata_i[PinW-1:0];
        RegDelays: delays_q  <= cfg_wdata_i[MapSlots*DelayW-1:0];
        RegFilter: filter_q  <= cfg_wdata_i[FilterW-1:0];
        default: ;  // index past the list is ignored
      endcase
    end
  end

  // handshake: the result register frees up when drained
  logic out_valid_q;
  logic accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // per channel pipelines; channels past four reuse the map field k mod 4
  chan_stat_t stat [CHANNELS];

  for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
    localparam int unsigned Slot = k % MapSlots;
    chan_cfg_t cfg;

    assign cfg.pin_sel = pin_map_q[Slot*PinSelW +: PinSelW];
    assign cfg.delay   = delays_q[Slot*DelayW +: DelayW];
    assign cfg.filter  = filter_q;

    vdq_channel u_chan (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (accept),
      .pins_i    (s_axis_tdata_i),
      .cfg_i     (cfg),
      .stat_o    (stat[k])
    );
  end

  // gather the first four channels; missing ones read as zero
  logic [ShownChannels-1:0] presence_v, valid_v;
  logic [DwellW-1:0]        dwell_v [ShownChannels];

  for (genvar k = 0; k < ShownChannels; k++) begin : g_shown
    if (k < CHANNELS) begin : g_have
      assign presence_v[k] = stat[k].presence;
      assign valid_v[k]    = stat[k].valid;
      assign dwell_v[k]    = stat[k].dwell;
    end else begin : g_none
      assign presence_v[k] = 1'b0;
      assign valid_v[k]    = 1'b0;
      assign dwell_v[k]    = '0;
    end
  end

  result_t result_d, result_q;

  assign result_d.presence_bits = presence_v;
  assign result_d.valid_bits    = valid_v;
  assign result_d.dwell0        = dwell_v[0];
  assign result_d.dwell1        = dwell_v[1];
  assign result_d.dwell2        = dwell_v[2];
  assign result_d.dwell3        = dwell_v[3];

  // result register
  logic out_valid_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = result_q;

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted item produced no result");

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while result stalled");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(result_q))
    else $error("stalled result overwritten");
`endif

endmodule

[sv/vdq_channel.sv]
module vdq_channel (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  logic [vdq_pkg::PinW-1:0]       pins_i,
  input  vdq_pkg::chan_cfg_t             cfg_i,
  output vdq_pkg::chan_stat_t            stat_o
);
  import vdq_pkg::*;

  // the timer stage's copy of the previous level always equals stable_q
  // after a tick, so the change test compares stable_d with stable_q

  logic [FilterW-1:0]   cnt_q, cnt_d, cnt_inc;
  logic                 stable_q, stable_d;
  logic [DwellW-1:0]    dwell_q, dwell_d;
  logic [DelayCntW-1:0] delay_q, delay_d, delay_inc, limit;
  logic                 valid_q, valid_d;
  logic                 level;

  assign level     = pins_i[cfg_i.pin_sel];
  assign cnt_inc   = cnt_q + FilterW'(1);
  assign delay_inc = delay_q + DelayCntW'(1);
  assign limit     = DelayCntW'(cfg_i.delay) * DelayUnit;

  always_comb begin
    cnt_d    = '0;
    stable_d = stable_q;
    if (level != stable_q) begin
      if (cnt_inc >= cfg_i.filter) begin
        stable_d = level;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_comb begin
    dwell_d = dwell_q;
    delay_d = delay_q;
    valid_d = valid_q;
    if (stable_d != stable_q) begin
      dwell_d = '0;
      if (stable_d) begin
        delay_d = DelayCntW'(1);
      end
    end else begin
      if (dwell_q != DwellMax) begin
        dwell_d = dwell_q + DwellW'(1);
      end
      if (delay_q != '0) begin
        if (delay_inc > limit) begin
          delay_d = '0;
          valid_d = 1'b1;
        end else begin
          delay_d = delay_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      stable_q <= 1'b0;
      dwell_q  <= '0;
      delay_q  <= '0;
      valid_q  <= 1'b0;
    end else if (advance_i) begin
      cnt_q    <= cnt_d;
      stable_q <= stable_d;
      dwell_q  <= dwell_d;
      delay_q  <= delay_d;
      valid_q  <= valid_d;
    end
  end

  // status after this tick, captured by the result register
  assign stat_o.presence = stable_d;
  assign stat_o.valid    = valid_d;
  assign stat_o.dwell    = dwell_d;

`ifndef SYNTH
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> valid_q)
    else $error("valid flag dropped");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(stable_q) && $stable(dwell_q) && $stable(delay_q))
    else $error("channel state moved without an item");

  a_dwell_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stable_q != $past(stable_q)) |-> (dwell_q == '0))
    else $error("dwell not cleared on state change");
`endif

endmodule
